@@ hw/rtl/mirrored_stripe_address_split_core_defines.svh @@
// Assertion macros used by the checker file of the stripe address split core.
// No dependencies; expects clk and arst_n in the scope of each use.
`ifndef MIRRORED_STRIPE_ADDRESS_SPLIT_CORE_DEFINES_SVH
`define MIRRORED_STRIPE_ADDRESS_SPLIT_CORE_DEFINES_SVH

// same-cycle implication
`define MSAS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/msas_pkg.sv @@
// Types, widths and helper functions of the mirrored stripe address split core.
// No dependencies; used by every module of the block.
package msas_pkg;

	localparam int OFF_W    = 31;
	localparam int LEN_W    = 12;
	localparam int DISK_W   = 5;
	localparam int PAIR_W   = 5;
	localparam int SS_W     = 17;
	localparam int CAP_W    = 32;
	localparam int ROW_W    = 32;
	localparam int QUOT_W   = 25;
	localparam int DVD_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int MAX_PAIRS = 16;
	localparam logic [SS_W-1:0]  STRIPE_MIN = 17'd64;
	localparam logic [SS_W-1:0]  STRIPE_MAX = 17'd65536;
	localparam logic [LEN_W-1:0] LEN_MAX    = 12'd4032;

	localparam logic [PAIR_W-1:0] PAIR_RST   = 5'd1;
	localparam logic [SS_W-1:0]   STRIPE_RST = 17'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIR_COUNT = 2'd0,
		REG_STRIPE_SIZE = 2'd1,
		REG_ARRAY_CAP = 2'd2
	} cfg_reg_t;

	// one request as handed from the front end to the chunk generator
	typedef struct packed {
		logic              err;
		logic [PAIR_W-1:0] pair;
		logic [ROW_W-1:0]  row;
		logic [SS_W-1:0]   intra;
		logic [LEN_W-1:0]  len;
	} job_t;

	function automatic logic [PAIR_W-1:0] clamp_pairs(input logic [PAIR_W-1:0] pc);
		logic [PAIR_W-1:0] r;
		begin
			r = pc;
			if (pc == '0)
				r = 5'd1;
			else if (int'(pc) > MAX_PAIRS)
				r = PAIR_W'(MAX_PAIRS);
			return r;
		end
	endfunction

	function automatic logic [SS_W-1:0] clamp_stripe(input logic [SS_W-1:0] s);
		logic [SS_W-1:0] r;
		begin
			r = s;
			if (s < STRIPE_MIN)
				r = STRIPE_MIN;
			else if (s > STRIPE_MAX)
				r = STRIPE_MAX;
			return r;
		end
	endfunction

	// one restoring divide step: {remainder, dividend shifted with quotient bit in}
	function automatic logic [SS_W+DVD_W-1:0] div_step(input logic [SS_W-1:0] rem,
			input logic [DVD_W-1:0] dvd, input logic [SS_W-1:0] dsr);
		logic [SS_W:0] t;
		logic          q;
		begin
			t = {rem, dvd[DVD_W-1]};
			q = 1'b0;
			if (t >= {1'b0, dsr}) begin
				t = t - {1'b0, dsr};
				q = 1'b1;
			end
			return {t[SS_W-1:0], dvd[DVD_W-2:0], q};
		end
	endfunction

endpackage

@@ hw/rtl/mirrored_stripe_address_split_core.sv @@
// Top level of the mirrored stripe address split core: config registers,
// front end, descriptor queue and chunk generator. Depends on msas_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | start_offset, request_length
//  out      | out_valid / out_ready| primary_disk, mirror_disk, disk_offset,
//           |                      | chunk_length, last_chunk, range_error
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// In the front end a request passes through offset by stripe division and
// stripe number by pair count on the shared divider, one multiply, one push.
// A rejected request skips straight to the push.
// The chunk generator loads a descriptor, then issues one word per cycle while
// out_ready holds; it works under the front end of the next request.
// Reset clears control state only; config resets to one pair, 256-byte stripes, zero capacity.
module mirrored_stripe_address_split_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [msas_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msas_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [msas_pkg::OFF_W-1:0]     start_offset,
	input  logic [msas_pkg::LEN_W-1:0]     request_length,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [msas_pkg::DISK_W-1:0]    primary_disk,
	output logic [msas_pkg::DISK_W-1:0]    mirror_disk,
	output logic [msas_pkg::OFF_W-1:0]     disk_offset,
	output logic [msas_pkg::LEN_W-1:0]     chunk_length,
	output logic                           last_chunk,
	output logic                           range_error
);
	import msas_pkg::*;

	logic [PAIR_W-1:0] pair_count_q;
	logic [SS_W-1:0]   stripe_size_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [PAIR_W-1:0] pairs;
	logic [SS_W-1:0]   stripe;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q  <= PAIR_RST;
			stripe_size_q <= STRIPE_RST;
			capacity_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PAIR_COUNT:  pair_count_q  <= cfg_data[PAIR_W-1:0];
				REG_STRIPE_SIZE: stripe_size_q <= cfg_data[SS_W-1:0];
				REG_ARRAY_CAP:   capacity_q    <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign pairs  = clamp_pairs(pair_count_q);
	assign stripe = clamp_stripe(stripe_size_q);

	msas_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_offset   (start_offset),
		.request_length (request_length),
		.pairs          (pairs),
		.stripe         (stripe),
		.capacity       (capacity_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_job       (push_job)
	);

	msas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	msas_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.pairs        (pairs),
		.stripe       (stripe),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.primary_disk (primary_disk),
		.mirror_disk  (mirror_disk),
		.disk_offset  (disk_offset),
		.chunk_length (chunk_length),
		.last_chunk   (last_chunk),
		.range_error  (range_error)
	);

endmodule

@@ hw/rtl/msas_queue.sv @@
// Two-entry queue of request descriptors between front end and chunk generator.
// Depends on msas_pkg.
module msas_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  msas_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output msas_pkg::job_t pop_job
);
	import msas_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ hw/rtl/msas_front.sv @@
// Front end: accepts requests, checks range, finds stripe, pair and row by a
// shared two-bit-per-cycle divider, scales the row. Depends on msas_pkg.
module msas_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [msas_pkg::OFF_W-1:0]   start_offset,
	input  logic [msas_pkg::LEN_W-1:0]   request_length,
	input  logic [msas_pkg::PAIR_W-1:0]  pairs,
	input  logic [msas_pkg::SS_W-1:0]    stripe,
	input  logic [msas_pkg::CAP_W-1:0]   capacity,
	output logic                         push_valid,
	input  logic                         push_ready,
	output msas_pkg::job_t               push_job
);
	import msas_pkg::*;

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_DIV1 = 5'b00010,
		F_DIV2 = 5'b00100,
		F_MUL  = 5'b01000,
		F_PUSH = 5'b10000
	} front_state_t;

	front_state_t          state_q;
	logic [DVD_W-1:0]      dvd_q;
	logic [SS_W-1:0]       rem_q;
	logic [SS_W-1:0]       dsr_q;
	logic [3:0]            cnt_q;
	logic [SS_W-1:0]       within_q;
	logic [LEN_W-1:0]      len_q;
	logic                  err_q;
	logic [PAIR_W-1:0]     pair_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [ROW_W-1:0]      row_q;

	logic [SS_W+DVD_W-1:0] step_a;
	logic [SS_W+DVD_W-1:0] step_b;
	logic [SS_W-1:0]       rem_nx;
	logic [DVD_W-1:0]      dvd_nx;
	logic [CAP_W-1:0]      end_sum;
	logic                  req_err;

	always_comb begin
		step_a = div_step(rem_q, dvd_q, dsr_q);
		step_b = div_step(step_a[SS_W+DVD_W-1:DVD_W], step_a[DVD_W-1:0], dsr_q);
		rem_nx = step_b[SS_W+DVD_W-1:DVD_W];
		dvd_nx = step_b[DVD_W-1:0];
	end

	assign end_sum  = {1'b0, start_offset} + {{(CAP_W-LEN_W){1'b0}}, request_length};
	assign req_err  = (end_sum > capacity) || (request_length > LEN_MAX);
	assign in_ready = (state_q == F_IDLE);

	assign push_valid      = (state_q == F_PUSH);
	assign push_job.err    = err_q;
	assign push_job.pair   = pair_q;
	assign push_job.row    = row_q;
	assign push_job.intra  = within_q;
	assign push_job.len    = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 4'd0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						err_q   <= req_err;
						cnt_q   <= 4'd15;
						state_q <= req_err ? F_PUSH : F_DIV1;
					end
				end
				F_DIV1: begin
					// 31-bit offset in a 32-bit dividend: 16 double steps
					cnt_q <= (cnt_q == 4'd0) ? 4'd12 : cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						state_q <= F_DIV2;
				end
				F_DIV2: begin
					// 25-bit stripe number in 26 dividend bits: 13 double steps
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0)
						state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				len_q    <= request_length;
				dvd_q    <= {1'b0, start_offset};
				rem_q    <= '0;
				dsr_q    <= stripe;
				// error words carry zero pair, row and offset
				pair_q   <= '0;
				row_q    <= '0;
				within_q <= '0;
			end
			F_DIV1: begin
				if (cnt_q == 4'd0) begin
					within_q <= rem_nx;
					dvd_q    <= {1'b0, dvd_nx[QUOT_W-1:0], 6'd0};
					rem_q    <= '0;
					dsr_q    <= {{(SS_W-PAIR_W){1'b0}}, pairs};
				end else begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
				end
			end
			F_DIV2: begin
				dvd_q <= dvd_nx;
				rem_q <= rem_nx;
				if (cnt_q == 4'd0) begin
					pair_q <= rem_nx[PAIR_W-1:0];
					quot_q <= dvd_nx[QUOT_W-1:0];
				end
			end
			F_MUL: begin
				row_q <= ROW_W'(quot_q * stripe);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/msas_back.sv @@
// Back end: walks one request descriptor stripe by stripe and drives the
// registered result word. Depends on msas_pkg.
module msas_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  msas_pkg::job_t              pop_job,
	input  logic [msas_pkg::PAIR_W-1:0] pairs,
	input  logic [msas_pkg::SS_W-1:0]   stripe,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [msas_pkg::DISK_W-1:0] primary_disk,
	output logic [msas_pkg::DISK_W-1:0] mirror_disk,
	output logic [msas_pkg::OFF_W-1:0]  disk_offset,
	output logic [msas_pkg::LEN_W-1:0]  chunk_length,
	output logic                        last_chunk,
	output logic                        range_error
);
	import msas_pkg::*;

	logic              act_q;
	logic              first_q;
	logic              err_q;
	logic [PAIR_W-1:0] pair_q;
	logic [ROW_W-1:0]  row_q;
	logic [SS_W-1:0]   within_q;
	logic [LEN_W-1:0]  rem_q;
	logic              out_valid_q;

	logic              emit;
	logic [SS_W-1:0]   avail;
	logic [LEN_W-1:0]  chunk;
	logic [LEN_W-1:0]  rem_nx;
	logic              wrap;
	logic [ROW_W-1:0]  first_off;

	assign pop_ready = !act_q;
	assign out_valid = out_valid_q;
	assign emit      = act_q && (!out_valid_q || out_ready);

	always_comb begin
		avail     = first_q ? (stripe - within_q) : stripe;
		chunk     = ({{(SS_W-LEN_W){1'b0}}, rem_q} <= avail) ? rem_q : avail[LEN_W-1:0];
		rem_nx    = rem_q - chunk;
		wrap      = (pair_q == pairs - 5'd1);
		first_off = row_q + {{(ROW_W-SS_W){1'b0}}, within_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (!act_q && pop_valid)
				act_q <= 1'b1;
			else if (emit && (err_q || rem_nx == '0))
				act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!act_q && pop_valid) begin
			first_q  <= 1'b1;
			err_q    <= pop_job.err;
			pair_q   <= pop_job.pair;
			row_q    <= pop_job.row;
			within_q <= pop_job.intra;
			rem_q    <= pop_job.len;
		end else if (emit) begin
			first_q <= 1'b0;
			rem_q   <= rem_nx;
			if (wrap) begin
				pair_q <= '0;
				row_q  <= row_q + {{(ROW_W-SS_W){1'b0}}, stripe};
			end else begin
				pair_q <= pair_q + 5'd1;
			end
		end
		if (emit) begin
			primary_disk <= {pair_q[DISK_W-2:0], 1'b0};
			mirror_disk  <= {pair_q[DISK_W-2:0], 1'b1};
			if (err_q) begin
				disk_offset  <= '0;
				chunk_length <= '0;
				last_chunk   <= 1'b1;
				range_error  <= 1'b1;
			end else begin
				disk_offset  <= first_q ? first_off[OFF_W-1:0] : row_q[OFF_W-1:0];
				chunk_length <= chunk;
				last_chunk   <= (rem_nx == '0);
				range_error  <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/msas_checker.sv @@
// Port-level checks of the mirrored stripe address split core, bound to the top.
// Depends on msas_pkg and mirrored_stripe_address_split_core_defines.svh.
`include "mirrored_stripe_address_split_core_defines.svh"

module msas_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [msas_pkg::DISK_W-1:0]    primary_disk,
	input logic [msas_pkg::DISK_W-1:0]    mirror_disk,
	input logic [msas_pkg::OFF_W-1:0]     disk_offset,
	input logic [msas_pkg::LEN_W-1:0]     chunk_length,
	input logic                           last_chunk,
	input logic                           range_error
);

	// a word offered and not taken is still offered next cycle
	`MSAS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out word dropped")

	// rejected requests give a single empty word
	`MSAS_ASSERT_IMPL(a_err_word, out_valid && range_error, last_chunk && primary_disk == 5'd0 && disk_offset == 31'd0 && chunk_length == 12'd0, "bad error word")

	// mirror is always the odd partner of the primary
	`MSAS_ASSERT_IMPL(a_pair_disks, out_valid, !primary_disk[0] && mirror_disk == primary_disk + 5'd1, "disk pair mismatch")

	// only the final word of a request may be empty
	`MSAS_ASSERT_IMPL(a_mid_chunk, out_valid && !last_chunk, chunk_length != 12'd0 && !range_error, "empty middle chunk")

endmodule

bind mirrored_stripe_address_split_core msas_checker u_msas_checker (.*);
